>>> design/rtpr_pkg.sv
// ----------------------------------------------------------------------------
// rtpr_pkg
// Shared types and constants of the packet reorder buffer.
// ----------------------------------------------------------------------------
package rtpr_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int SEQ_W     = 16;
	localparam int TAG_W     = 32;
	localparam int LEN_W     = 16;
	localparam int CNT_W     = 32;
	localparam int WS_W      = 6;
	localparam int SIZE_MIN  = 4;
	localparam logic [WS_W-1:0] WS_RESET = 6'd32;

	localparam logic OP_PUSH   = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;
	localparam logic KIND_REL  = 1'b0;
	localparam logic KIND_STAT = 1'b1;

	typedef enum logic [1:0] {
		OUT_OK    = 2'd0,
		OUT_DISC  = 2'd1,
		OUT_RESET = 2'd2
	} outcome_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLASSIFY,
		S_FLUSH,
		S_AHEAD,
		S_DRAIN,
		S_ADV,
		S_STORE,
		S_REL_NEW,
		S_STATUS
	} state_t;

	typedef enum logic [1:0] {
		L_FLUSH,
		L_AHEAD,
		L_DRAIN
	} loop_t;

	typedef struct packed {
		logic load;
		logic clr_first;
		logic store;
		logic set_end;
		logic discard;
		logic set_reset;
		logic advance;
		logic emit_new;
		logic emit_status;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic in_win;
		logic slot_busy;
		logic ahead;
		logic late;
		logic end_valid;
		logic ahead_more;
		logic cur_full;
		logic out_free;
	} stat_t;

endpackage

>>> design/rtp_reorder_buffer.sv
// ----------------------------------------------------------------------------
// rtp_reorder_buffer
// Sequence-number reorder window for packet tags, with statistics.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    opcode, seq_num, packet_tag, packet_length
//  out      out_valid/out_ready  kind, out_tag, out_seq, outcome, counters, last
//  cfg      cfg_we               cfg_wdata (window size)
//
// A request passes one accept state, one classify state for a push, a check and
// then an act state per slot walked by the advance, flush or drain loops (the act
// state works on the registered tag memory read; a release leaves in it) plus one
// final check, one state to store a packet ahead of the window, one to release a
// restarting packet and one for the status.
// Reset empties the window. A stalled output holds the sequencer in its
// emitting state.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer #(
	parameter int DEPTH = rtpr_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rtpr_pkg::WS_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [rtpr_pkg::SEQ_W-1:0]    seq_num,
	input  logic [rtpr_pkg::TAG_W-1:0]    packet_tag,
	input  logic [rtpr_pkg::LEN_W-1:0]    packet_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [rtpr_pkg::TAG_W-1:0]    out_tag,
	output logic [rtpr_pkg::SEQ_W-1:0]    out_seq,
	output logic [1:0]                    outcome,
	output logic [rtpr_pkg::CNT_W-1:0]    packets_total,
	output logic [rtpr_pkg::CNT_W-1:0]    bytes_total,
	output logic [rtpr_pkg::CNT_W-1:0]    discarded_total,
	output logic [rtpr_pkg::CNT_W-1:0]    lost_total,
	output logic                          last
);

	rtpr_pkg::cmd_t  cmd;
	rtpr_pkg::stat_t st;

	rtpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rtpr_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.opcode          (opcode),
		.seq_num         (seq_num),
		.packet_tag      (packet_tag),
		.packet_length   (packet_length),
		.cmd             (cmd),
		.st              (st),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.kind            (kind),
		.out_tag         (out_tag),
		.out_seq         (out_seq),
		.outcome         (outcome),
		.packets_total   (packets_total),
		.bytes_total     (bytes_total),
		.discarded_total (discarded_total),
		.lost_total      (lost_total),
		.last            (last)
	);

endmodule

>>> design/rtpr_ctrl.sv
// ----------------------------------------------------------------------------
// rtpr_ctrl
// Command sequencer: classifies a request and walks the window advance loops.
// ----------------------------------------------------------------------------
module rtpr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            opcode,
	output logic            in_ready,
	input  rtpr_pkg::stat_t st,
	output rtpr_pkg::cmd_t  cmd
);

	rtpr_pkg::state_t state_q, state_d;
	rtpr_pkg::loop_t  ret_q, ret_d;
	logic             restart_q, restart_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rtpr_pkg::S_IDLE;
			ret_q     <= rtpr_pkg::L_DRAIN;
			restart_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_q     <= ret_d;
			restart_q <= restart_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		restart_d = restart_q;
		unique case (state_q)
			rtpr_pkg::S_IDLE: begin
				if (in_valid) begin
					restart_d = 1'b0;
					state_d = (opcode == rtpr_pkg::OP_PUSH) ? rtpr_pkg::S_CLASSIFY
						: rtpr_pkg::S_FLUSH;
				end
			end
			rtpr_pkg::S_CLASSIFY: begin
				if (st.first) state_d = rtpr_pkg::S_REL_NEW;
				else if (st.in_win) state_d = rtpr_pkg::S_DRAIN;
				else if (st.ahead) state_d = rtpr_pkg::S_AHEAD;
				else if (st.late) state_d = rtpr_pkg::S_DRAIN;
				else begin
					restart_d = 1'b1;
					state_d = rtpr_pkg::S_FLUSH;
				end
			end
			rtpr_pkg::S_FLUSH: begin
				if (st.end_valid) begin
					ret_d = rtpr_pkg::L_FLUSH;
					state_d = rtpr_pkg::S_ADV;
				end else begin
					state_d = restart_q ? rtpr_pkg::S_REL_NEW : rtpr_pkg::S_STATUS;
				end
			end
			rtpr_pkg::S_AHEAD: begin
				if (st.ahead_more) begin
					ret_d = rtpr_pkg::L_AHEAD;
					state_d = rtpr_pkg::S_ADV;
				end else begin
					state_d = rtpr_pkg::S_STORE;
				end
			end
			rtpr_pkg::S_DRAIN: begin
				if (st.cur_full) begin
					ret_d = rtpr_pkg::L_DRAIN;
					state_d = rtpr_pkg::S_ADV;
				end else begin
					state_d = rtpr_pkg::S_STATUS;
				end
			end
			rtpr_pkg::S_ADV: begin
				if (!st.cur_full || st.out_free) begin
					unique case (ret_q)
						rtpr_pkg::L_FLUSH: state_d = rtpr_pkg::S_FLUSH;
						rtpr_pkg::L_AHEAD: state_d = rtpr_pkg::S_AHEAD;
						default:           state_d = rtpr_pkg::S_DRAIN;
					endcase
				end
			end
			rtpr_pkg::S_STORE: state_d = rtpr_pkg::S_DRAIN;
			rtpr_pkg::S_REL_NEW: begin
				if (st.out_free) state_d = rtpr_pkg::S_DRAIN;
			end
			rtpr_pkg::S_STATUS: begin
				if (st.out_free) state_d = rtpr_pkg::S_IDLE;
			end
			default: state_d = rtpr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rtpr_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			rtpr_pkg::S_CLASSIFY: begin
				if (st.first) begin
					cmd.clr_first = 1'b1;
				end else if (st.in_win) begin
					cmd.store   = !st.slot_busy;
					cmd.discard = st.slot_busy;
				end else if (st.ahead) begin
					cmd.store = 1'b0;
				end else if (st.late) begin
					cmd.discard = 1'b1;
				end else begin
					cmd.set_reset = 1'b1;
				end
			end
			rtpr_pkg::S_ADV:     cmd.advance = !st.cur_full || st.out_free;
			rtpr_pkg::S_STORE: begin
				cmd.store   = 1'b1;
				cmd.set_end = 1'b1;
			end
			rtpr_pkg::S_REL_NEW: cmd.emit_new = st.out_free;
			rtpr_pkg::S_STATUS:  cmd.emit_status = st.out_free;
			default: ;
		endcase
	end

endmodule

>>> design/rtpr_dp.sv
// ----------------------------------------------------------------------------
// rtpr_dp
// Window state, slot tag memory, statistics counters and the result register.
// ----------------------------------------------------------------------------
module rtpr_dp #(
	parameter int DEPTH = rtpr_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rtpr_pkg::WS_W-1:0]     cfg_wdata,
	input  logic                          opcode,
	input  logic [rtpr_pkg::SEQ_W-1:0]    seq_num,
	input  logic [rtpr_pkg::TAG_W-1:0]    packet_tag,
	input  logic [rtpr_pkg::LEN_W-1:0]    packet_length,
	input  rtpr_pkg::cmd_t                cmd,
	output rtpr_pkg::stat_t               st,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          kind,
	output logic [rtpr_pkg::TAG_W-1:0]    out_tag,
	output logic [rtpr_pkg::SEQ_W-1:0]    out_seq,
	output logic [1:0]                    outcome,
	output logic [rtpr_pkg::CNT_W-1:0]    packets_total,
	output logic [rtpr_pkg::CNT_W-1:0]    bytes_total,
	output logic [rtpr_pkg::CNT_W-1:0]    discarded_total,
	output logic [rtpr_pkg::CNT_W-1:0]    lost_total,
	output logic                          last
);

	// the 6-bit size register never selects more than 63 slots
	localparam int SLOTS = (DEPTH < 64) ? DEPTH : 64;
	localparam int IW    = $clog2(SLOTS);

	logic [rtpr_pkg::WS_W-1:0]  ws_q;
	logic [SLOTS-1:0]           full_q;
	logic [rtpr_pkg::TAG_W-1:0] mem [SLOTS];
	logic [rtpr_pkg::TAG_W-1:0] rd_q;
	logic [rtpr_pkg::SEQ_W-1:0] next_q, end_q, seq_q;
	logic [rtpr_pkg::TAG_W-1:0] tag_q;
	logic [IW-1:0]              rs_q;
	logic                       endv_q, first_q;
	logic [1:0]                 oc_q;
	logic [rtpr_pkg::CNT_W-1:0] pk_q, by_q, di_q, lo_q;

	logic [6:0]                 size7;
	logic [IW:0]                size;
	logic [rtpr_pkg::SEQ_W-1:0] size16, endv, lo_late, offs;
	logic [rtpr_pkg::SEQ_W-1:0] dist_floor;
	logic [IW:0]                sum;
	logic [IW-1:0]              idx, rs_inc;

	always_comb begin
		if (ws_q < rtpr_pkg::WS_W'(rtpr_pkg::SIZE_MIN)) size7 = 7'(rtpr_pkg::SIZE_MIN);
		else if (int'(ws_q) > DEPTH) size7 = 7'(DEPTH);
		else size7 = {1'b0, ws_q};
	end
	assign size   = size7[IW:0];
	assign size16 = rtpr_pkg::SEQ_W'(size);
	assign endv   = endv_q ? end_q : next_q;

	// slot of the held sequence number, offset stays below the size
	assign offs = seq_q - next_q;
	assign sum  = {1'b0, rs_q} + offs[IW:0];
	assign idx  = (sum >= size) ? IW'(sum - size) : sum[IW-1:0];
	assign rs_inc = ({1'b0, rs_q} + 1'b1 == size) ? '0 : IW'({1'b0, rs_q} + 1'b1);

	assign lo_late = endv - (size16 << 1);

	assign dist_floor = next_q - (seq_q - (size16 - 16'd1));

	always_comb begin
		st.first      = first_q;
		st.in_win     = (seq_q - next_q) <= (endv - next_q);
		st.slot_busy  = full_q[idx];
		st.ahead      = (seq_q - endv) <= (size16 - 16'd1);
		st.late       = (seq_q - lo_late) <= (next_q - lo_late);
		st.end_valid  = endv_q;
		st.ahead_more = dist_floor[rtpr_pkg::SEQ_W-1];
		st.cur_full   = full_q[rs_q];
		st.out_free   = !out_valid || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.store) mem[idx] <= tag_q;
		rd_q <= mem[rs_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q <= seq_num;
			tag_q <= packet_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= rtpr_pkg::WS_RESET;
			full_q  <= '0;
			next_q  <= '0;
			end_q   <= '0;
			rs_q    <= '0;
			endv_q  <= 1'b0;
			first_q <= 1'b1;
			oc_q    <= rtpr_pkg::OUT_OK;
			pk_q    <= '0;
			by_q    <= '0;
			di_q    <= '0;
			lo_q    <= '0;
		end else if (cfg_we) begin
			// empty the window, keep next_seq and counters
			ws_q    <= cfg_wdata;
			full_q  <= '0;
			rs_q    <= '0;
			endv_q  <= 1'b0;
			first_q <= 1'b1;
		end else begin
			if (cmd.load) begin
				oc_q <= rtpr_pkg::OUT_OK;
				if (opcode == rtpr_pkg::OP_PUSH) begin
					pk_q <= pk_q + 1'b1;
					by_q <= by_q + rtpr_pkg::CNT_W'(packet_length);
				end
			end
			if (cmd.clr_first) first_q <= 1'b0;
			if (cmd.store) full_q[idx] <= 1'b1;
			if (cmd.set_end) begin
				endv_q <= 1'b1;
				end_q  <= seq_q;
			end
			if (cmd.discard) begin
				di_q <= di_q + 1'b1;
				oc_q <= rtpr_pkg::OUT_DISC;
			end
			if (cmd.set_reset) oc_q <= rtpr_pkg::OUT_RESET;
			if (cmd.advance) begin
				if (full_q[rs_q]) full_q[rs_q] <= 1'b0;
				else lo_q <= lo_q + 1'b1;
				if (endv_q && next_q == end_q) endv_q <= 1'b0;
				next_q <= next_q + 1'b1;
				rs_q   <= rs_inc;
			end
			if (cmd.emit_new) begin
				next_q <= seq_q + 1'b1;
				endv_q <= 1'b0;
			end
		end
	end

	logic emit;
	assign emit = (cmd.advance && full_q[rs_q]) || cmd.emit_new || cmd.emit_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (emit) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind            <= cmd.emit_status ? rtpr_pkg::KIND_STAT : rtpr_pkg::KIND_REL;
			out_tag         <= cmd.emit_status ? '0 : (cmd.emit_new ? tag_q : rd_q);
			out_seq         <= cmd.emit_status ? '0 : (cmd.emit_new ? seq_q : next_q);
			outcome         <= cmd.emit_status ? oc_q : rtpr_pkg::OUT_OK;
			packets_total   <= cmd.emit_status ? pk_q : '0;
			bytes_total     <= cmd.emit_status ? by_q : '0;
			discarded_total <= cmd.emit_status ? di_q : '0;
			lost_total      <= cmd.emit_status ? lo_q : '0;
			last            <= cmd.emit_status;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid || out_ready))
		else $error("result overwritten while stalled");
	a_rs_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rs_q} < size)
		else $error("read slot beyond window size");
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		endv_q |-> ((end_q - next_q) < size16))
		else $error("window span exceeds size");
	a_adv_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> !(cmd.store || cmd.emit_new || cmd.load))
		else $error("advance overlaps another command");

endmodule

>>> dv/rtp_reorder_checker.sv
// ----------------------------------------------------------------------------
// rtp_reorder_checker
// Watches the request and result channels of the reorder buffer, keeps its
// own copy of the reorder window, and compares every result field by field.
// ----------------------------------------------------------------------------
module rtp_reorder_checker
	import rtpr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [WS_W-1:0]  cfg_wdata,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             opcode,
	input  logic [SEQ_W-1:0] seq_num,
	input  logic [TAG_W-1:0] packet_tag,
	input  logic [LEN_W-1:0] packet_length,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic             kind,
	input  logic [TAG_W-1:0] out_tag,
	input  logic [SEQ_W-1:0] out_seq,
	input  logic [1:0]       outcome,
	input  logic [CNT_W-1:0] packets_total,
	input  logic [CNT_W-1:0] bytes_total,
	input  logic [CNT_W-1:0] discarded_total,
	input  logic [CNT_W-1:0] lost_total,
	input  logic             last,
	output int               fail_count,
	output int               pending,
	output int               releases_seen,
	output int               resets_seen,
	output int               discards_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = DEPTH_DEF;

	typedef struct packed {
		logic             kind;
		logic [TAG_W-1:0] tag;
		logic [SEQ_W-1:0] seq;
		logic [1:0]       outcome;
		logic [CNT_W-1:0] pkts;
		logic [CNT_W-1:0] bytes;
		logic [CNT_W-1:0] disc;
		logic [CNT_W-1:0] lost;
		logic             last;
	} pkt_result_t;

	pkt_result_t expected_results[$];

	logic [WS_W-1:0]  win_reg;
	logic             full_q[DEPTH];
	logic [TAG_W-1:0] tag_q[DEPTH];
	logic [SEQ_W-1:0] head_seq;
	int               head_slot;
	logic             tail_ok;
	logic [SEQ_W-1:0] tail_seq;
	logic             fresh;
	logic [CNT_W-1:0] n_pkts, n_bytes, n_disc, n_lost;

	function automatic int win_len();
		int s;
		s = win_reg;
		if (s < SIZE_MIN) s = SIZE_MIN;
		if (s > DEPTH) s = DEPTH;
		return s;
	endfunction

	function automatic logic seq_within(logic [SEQ_W-1:0] x, logic [SEQ_W-1:0] lo,
			logic [SEQ_W-1:0] hi);
		logic [SEQ_W-1:0] a, b;
		a = x - lo;
		b = hi - lo;
		return a <= b;
	endfunction

	function automatic logic seq_older(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = a - b;
		return d[SEQ_W-1];
	endfunction

	function automatic int slot_for(logic [SEQ_W-1:0] s);
		logic [SEQ_W-1:0] d;
		d = s - head_seq;
		return (head_slot + int'(d)) % win_len();
	endfunction

	task automatic push_release(logic [TAG_W-1:0] t, logic [SEQ_W-1:0] s);
		pkt_result_t r;
		r = '0;
		r.kind = KIND_REL;
		r.tag = t;
		r.seq = s;
		expected_results.push_back(r);
	endtask

	task automatic step_head();
		int r;
		r = head_slot % win_len();
		if (full_q[r]) begin
			push_release(tag_q[r], head_seq);
			full_q[r] = 1'b0;
		end else begin
			n_lost++;
		end
		if (tail_ok && head_seq == tail_seq) tail_ok = 1'b0;
		head_seq++;
		head_slot = (r + 1) % win_len();
	endtask

	task automatic drain_window();
		logic [SEQ_W-1:0] target;
		int g;
		g = 0;
		if (!tail_ok) return;
		target = tail_seq + 1'b1;
		while (head_seq != target && g <= win_len()) begin
			step_head();
			g++;
		end
	endtask

	task automatic restart_at(logic [TAG_W-1:0] t, logic [SEQ_W-1:0] s);
		drain_window();
		push_release(t, s);
		head_seq = s + 1'b1;
		tail_ok = 1'b0;
	endtask

	task automatic sort_packet(logic [SEQ_W-1:0] s, logic [TAG_W-1:0] t,
			output outcome_t oc);
		int sz, idx, g;
		logic [SEQ_W-1:0] endv, lowest;
		sz = win_len();
		oc = OUT_OK;
		if (fresh) begin
			fresh = 1'b0;
			restart_at(t, s);
			return;
		end
		endv = tail_ok ? tail_seq : head_seq;
		if (seq_within(s, head_seq, endv)) begin
			idx = slot_for(s);
			if (!full_q[idx]) begin
				full_q[idx] = 1'b1;
				tag_q[idx] = t;
			end else begin
				n_disc++;
				oc = OUT_DISC;
			end
		end else if (seq_within(s, endv, endv + SEQ_W'(sz - 1))) begin
			lowest = s - SEQ_W'(sz - 1);
			g = 0;
			while (seq_older(head_seq, lowest) && g < sz) begin
				step_head();
				g++;
			end
			idx = slot_for(s);
			full_q[idx] = 1'b1;
			tag_q[idx] = t;
			tail_ok = 1'b1;
			tail_seq = s;
		end else if (seq_within(s, endv - SEQ_W'(2 * sz), head_seq)) begin
			n_disc++;
			oc = OUT_DISC;
		end else begin
			restart_at(t, s);
			oc = OUT_RESET;
		end
	endtask

	task automatic predict_request(logic op, logic [SEQ_W-1:0] s, logic [TAG_W-1:0] t,
			logic [LEN_W-1:0] len);
		outcome_t oc;
		pkt_result_t st;
		int g;
		oc = OUT_OK;
		g = 0;
		head_slot = head_slot % win_len();
		if (op == OP_PUSH) begin
			n_pkts++;
			n_bytes += len;
			sort_packet(s, t, oc);
			while (full_q[head_slot] && g <= win_len()) begin
				step_head();
				g++;
			end
		end else begin
			drain_window();
		end
		st = '0;
		st.kind = KIND_STAT;
		st.outcome = oc;
		st.pkts = n_pkts;
		st.bytes = n_bytes;
		st.disc = n_disc;
		st.lost = n_lost;
		st.last = 1'b1;
		expected_results.push_back(st);
	endtask

	task automatic report_mismatch(string what, logic [CNT_W-1:0] got,
			logic [CNT_W-1:0] want);
		$display("%0t ns: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		releases_seen = 0;
		resets_seen = 0;
		discards_seen = 0;
		win_reg = WS_RESET;
		for (int i = 0; i < DEPTH; i++) begin
			full_q[i] = 1'b0;
			tag_q[i] = '0;
		end
		head_seq = '0;
		head_slot = 0;
		tail_ok = 1'b0;
		tail_seq = '0;
		fresh = 1'b1;
		n_pkts = '0;
		n_bytes = '0;
		n_disc = '0;
		n_lost = '0;
	end

	always @(posedge clk) begin
		pkt_result_t w;
		if (arst_n) begin
			if (cfg_we) begin
				win_reg = cfg_wdata;
				for (int i = 0; i < DEPTH; i++) full_q[i] = 1'b0;
				head_slot = 0;
				tail_ok = 1'b0;
				fresh = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result kind", kind, '0);
				end else begin
					w = expected_results.pop_front();
					if (kind == KIND_REL) releases_seen++;
					else if (outcome == OUT_RESET) resets_seen++;
					else if (outcome == OUT_DISC) discards_seen++;
					if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
					if (out_tag !== w.tag) report_mismatch("out_tag", out_tag, w.tag);
					if (out_seq !== w.seq) report_mismatch("out_seq", out_seq, w.seq);
					if (outcome !== w.outcome) report_mismatch("outcome", outcome, w.outcome);
					if (packets_total !== w.pkts)
						report_mismatch("packets_total", packets_total, w.pkts);
					if (bytes_total !== w.bytes)
						report_mismatch("bytes_total", bytes_total, w.bytes);
					if (discarded_total !== w.disc)
						report_mismatch("discarded_total", discarded_total, w.disc);
					if (lost_total !== w.lost)
						report_mismatch("lost_total", lost_total, w.lost);
					if (last !== w.last) report_mismatch("last", last, w.last);
				end
			end
			if (in_valid && in_ready)
				predict_request(opcode, seq_num, packet_tag, packet_length);
			pending = expected_results.size();
		end
	end

endmodule

>>> dv/rtp_reorder_buffer_tb.sv
// ----------------------------------------------------------------------------
// rtp_reorder_buffer_tb
// Drives directed and random push and flush requests through several window
// sizes, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rtpr_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [WS_W-1:0]  cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	logic             opcode;
	logic [SEQ_W-1:0] seq_num;
	logic [TAG_W-1:0] packet_tag;
	logic [LEN_W-1:0] packet_length;
	logic             out_valid;
	logic             out_ready;
	logic             kind;
	logic [TAG_W-1:0] out_tag;
	logic [SEQ_W-1:0] out_seq;
	logic [1:0]       outcome;
	logic [CNT_W-1:0] packets_total, bytes_total, discarded_total, lost_total;
	logic             last;

	int fail_count, pending, releases_seen, resets_seen, discards_seen;
	int cycles;
	int requests_sent;
	logic stall_hold;
	logic [SEQ_W-1:0] base_seq;

	rtp_reorder_buffer dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .seq_num(seq_num),
		.packet_tag(packet_tag), .packet_length(packet_length),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind), .out_tag(out_tag),
		.out_seq(out_seq), .outcome(outcome), .packets_total(packets_total),
		.bytes_total(bytes_total), .discarded_total(discarded_total),
		.lost_total(lost_total), .last(last)
	);

	rtp_reorder_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .seq_num(seq_num),
		.packet_tag(packet_tag), .packet_length(packet_length),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind), .out_tag(out_tag),
		.out_seq(out_seq), .outcome(outcome), .packets_total(packets_total),
		.bytes_total(bytes_total), .discarded_total(discarded_total),
		.lost_total(lost_total), .last(last), .fail_count(fail_count),
		.pending(pending), .releases_seen(releases_seen), .resets_seen(resets_seen),
		.discards_seen(discards_seen)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		opcode = OP_PUSH;
		seq_num = '0;
		packet_tag = '0;
		packet_length = '0;
		out_ready = 1'b0;
		stall_hold = 1'b0;
		requests_sent = 0;
		base_seq = '0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("rtp_reorder_buffer test failed");
			$finish;
		end
	end
	initial cycles = 0;

	// receiver: random gap per result; a long hold-off when asked
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (stall_hold) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				stall_hold = 1'b0;
			end else if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// valid stays up between back-to-back requests; drop it during a gap
	task automatic send_request(logic op, logic [SEQ_W-1:0] s, logic [TAG_W-1:0] t,
			logic [LEN_W-1:0] len, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 15);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		seq_num <= s;
		packet_tag <= t;
		packet_length <= len;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic push_pkt(logic [SEQ_W-1:0] s);
		send_request(OP_PUSH, s, $urandom, LEN_W'($urandom), 1'b0);
	endtask

	task automatic write_window(logic [WS_W-1:0] v);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly a stream near the window with some reordering, plus noise
	task automatic random_phase(int count, int sz);
		int r;
		logic [SEQ_W-1:0] s;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				s = base_seq + SEQ_W'($urandom_range(0, sz - 1));
				if ($urandom_range(0, 2) == 0) base_seq = base_seq + 1'b1;
			end else if (r < 72) begin
				s = base_seq + SEQ_W'($urandom_range(sz, 2 * sz));
				base_seq = s - SEQ_W'(sz / 2);
			end else if (r < 82) begin
				s = base_seq - SEQ_W'($urandom_range(1, 3 * sz));
			end else if (r < 90) begin
				s = $urandom;
				base_seq = s;
			end else begin
				s = base_seq;
			end
			if (r >= 95) send_request(OP_FLUSH, $urandom, $urandom, LEN_W'($urandom), 1'b0);
			else push_pkt(s);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: flush when empty, first packet, store, ahead, late, dup, far
		send_request(OP_FLUSH, 16'h0000, 32'h0, 16'h0, 1'b1);
		push_pkt(16'hFFFE);
		push_pkt(16'h0001);
		push_pkt(16'h0003);
		push_pkt(16'h0003);
		push_pkt(16'hFFFF);
		push_pkt(16'hFFF0);
		push_pkt(16'h0020);
		send_request(OP_PUSH, 16'h0005, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		send_request(OP_PUSH, 16'h0006, 32'h0000_0000, 16'h0000, 1'b1);
		send_request(OP_FLUSH, 16'h1234, 32'h0, 16'h0, 1'b0);
		push_pkt(16'h8000);
		push_pkt(16'h0000);
		push_pkt(16'h7FFF);
		push_pkt(16'h8001);
		send_request(OP_FLUSH, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);

		base_seq = 16'h0010;
		write_window(6'd0);
		push_pkt(16'hFFFD);
		push_pkt(16'h0001);
		push_pkt(16'h0003);
		push_pkt(16'h0000);
		push_pkt(16'h0004);
		push_pkt(16'h0002);
		send_request(OP_FLUSH, 16'h0, 32'h0, 16'h0, 1'b0);

		write_window(6'd4);
		base_seq = $urandom;
		random_phase(80, 4);

		// long output stall while requests keep coming
		write_window(6'd63);
		base_seq = $urandom;
		stall_hold = 1'b1;
		random_phase(100, 32);

		write_window(6'd9);
		base_seq = 16'hFFF0;
		random_phase(90, 9);

		write_window(6'd32);
		base_seq = $urandom;
		random_phase(100, 32);
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d requests sent, %0d packets released, %0d window resets, %0d discards",
			requests_sent, releases_seen, resets_seen, discards_seen);
		$display("window sizes 0, 4, 9, 32 and 63 exercised with random gaps and a long stall");
		if (fail_count == 0) begin
			$display("rtp_reorder_buffer test passed");
		end else begin
			$display("rtp_reorder_buffer test failed");
		end
		$finish;
	end

endmodule
